// ----- src/bnrs_pkg.sv -----
package bnrs_pkg;

  // Polynomial length that caps the wanted coefficient count.
  localparam int POLY_LENGTH = 256;

  localparam int ByteW    = 8;
  localparam int ValueW   = 19;
  localparam int SmallW   = 3;
  localparam int LargeW   = 18;
  localparam int WantedW  = 9;
  localparam int IndexW   = 8;
  localparam int GatherW  = 32;
  localparam int GCountW  = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 18;

  // Result queue between the classifier and the output stage.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSamplerMode  = 2'd0,
    CfgSmallBound   = 2'd1,
    CfgLargeBound   = 2'd2,
    CfgCoeffsWanted = 2'd3
  } cfg_reg_e;

  // One accepted candidate on its way to the output stage.
  typedef struct packed {
    logic [ValueW-1:0] sample;
    logic [LargeW-1:0] bound;
    logic [IndexW-1:0] index;
    logic              done;
    logic              last;
  } bnrs_entry_t;

  // Up to two entries written into the queue in one cycle; first is the
  // earlier one in result order.
  typedef struct packed {
    logic [1:0]  count;
    bnrs_entry_t first;
    bnrs_entry_t second;
  } bnrs_push_t;

endpackage

// ----- src/bnrs_front.sv -----
module bnrs_front import bnrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [ByteW-1:0]    in_byte_i,
  input  logic                in_eob_i,
  input  logic                in_restart_i,
  output bnrs_push_t          push_o
);

  localparam logic [10:0] PolyLen = 11'(POLY_LENGTH);

  logic                mode_q;
  logic [SmallW-1:0]   small_q;
  logic [LargeW-1:0]   large_q;
  logic [WantedW-1:0]  wanted_q;
  logic [GatherW-1:0]  gather_q, gather_d;
  logic [GCountW-1:0]  gcount_q, gcount_d;
  logic [WantedW-1:0]  produced_q, produced_d;

  logic                in_fire;
  logic [GatherW-1:0]  gather_eff;
  logic [GCountW-1:0]  gcount_eff;
  logic [WantedW-1:0]  pc0, pc1;
  logic                group_full, cand_valid;
  logic [ValueW-1:0]   t0, t1, bound2;
  logic [LargeW-1:0]   bound;
  logic [WantedW-1:0]  limit;
  logic                acc0, acc1;
  bnrs_entry_t         e0, e1;

  assign in_fire = in_valid_i && in_ready_i;

  always_comb begin
    // A restart clears the count and the gather before this byte is used.
    gather_eff = in_restart_i ? '0 : gather_q;
    gcount_eff = in_restart_i ? '0 : gcount_q;
    pc0        = in_restart_i ? '0 : produced_q;

    limit = ({2'b00, wanted_q} > PolyLen) ? PolyLen[WantedW-1:0] : wanted_q;

    group_full = mode_q && (gcount_eff >= GCountW'(4));
    cand_valid = !mode_q || group_full;

    if (mode_q) begin
      t0    = gather_eff[ValueW-1:0];
      t1    = {in_byte_i[6:0], gather_eff[31:20]};
      bound = large_q;
    end else begin
      t0    = {15'd0, in_byte_i[3:0]};
      t1    = {15'd0, in_byte_i[7:4]};
      bound = {15'd0, small_q};
    end
    bound2 = {bound, 1'b0};

    acc0 = cand_valid && (pc0 < limit) && (t0 <= bound2);
    pc1  = pc0 + WantedW'(acc0);
    acc1 = cand_valid && (pc1 < limit) && (t1 <= bound2);
    produced_d = pc1 + WantedW'(acc1);

    e0.sample = t0;
    e0.bound  = bound;
    e0.index  = pc0[IndexW-1:0];
    e0.done   = ((pc0 + 9'd1) == limit);
    e0.last   = !acc1;
    e1.sample = t1;
    e1.bound  = bound;
    e1.index  = pc1[IndexW-1:0];
    e1.done   = ((pc1 + 9'd1) == limit);
    e1.last   = 1'b1;

    push_o.count  = in_fire ? {acc0 && acc1, acc0 ^ acc1} : 2'd0;
    push_o.first  = acc0 ? e0 : e1;
    push_o.second = e1;
  end

  // Gather update: large mode collects four bytes, the fifth completes the group.
  always_comb begin
    gather_d = gather_eff;
    gcount_d = gcount_eff;
    if (mode_q) begin
      if (group_full || in_eob_i) begin
        gather_d = '0;
        gcount_d = '0;
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (gcount_eff[1:0] == 2'(k)) begin
            gather_d[8*k +: 8] = in_byte_i;
          end
        end
        gcount_d = gcount_eff + GCountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      small_q    <= 3'd2;
      large_q    <= 18'd131071;
      wanted_q   <= 9'd256;
      gather_q   <= '0;
      gcount_q   <= '0;
      produced_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgSamplerMode: begin
          mode_q   <= cfg_data_i[0];
          gather_q <= '0;
          gcount_q <= '0;
        end
        CfgSmallBound:   small_q  <= cfg_data_i[SmallW-1:0];
        CfgLargeBound:   large_q  <= cfg_data_i[LargeW-1:0];
        CfgCoeffsWanted: wanted_q <= cfg_data_i[WantedW-1:0];
        default: ;
      endcase
    end else if (in_fire) begin
      gather_q   <= gather_d;
      gcount_q   <= gcount_d;
      produced_q <= produced_d;
    end
  end

endmodule

// ----- src/bnrs_queue.sv -----
module bnrs_queue import bnrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bnrs_push_t  push_i,
  output logic        space_o,
  input  logic        pop_i,
  output logic        valid_o,
  output bnrs_entry_t entry_o
);

  bnrs_entry_t      slots_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] count_q, count_d;
  logic [QPtrW-1:0] wptr_next;

  // Room for the two results a single byte may cause.
  assign space_o   = (count_q <= QCntW'(QDepth - 2));
  assign valid_o   = (count_q != '0);
  assign entry_o   = slots_q[rptr_q];
  assign wptr_next = wptr_q + QPtrW'(1);
  assign count_d   = count_q + QCntW'(push_i.count) - QCntW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      slots_q[wptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      slots_q[wptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + QPtrW'(push_i.count);
      if (pop_i) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

// ----- src/bnrs_back.sv -----
module bnrs_back import bnrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  bnrs_entry_t       entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValueW-1:0] coef_o,
  output logic [IndexW-1:0] index_o,
  output logic              done_o,
  output logic              last_o
);

  logic              valid_q;
  logic [ValueW-1:0] coef_q;
  logic [IndexW-1:0] index_q;
  logic              done_q, last_q;
  logic              load;

  assign load  = valid_i && (!valid_q || out_ready_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Bound minus sample, kept as 19-bit two's complement.
  always_ff @(posedge clk_i) begin
    if (load) begin
      coef_q  <= {1'b0, entry_i.bound} - entry_i.sample;
      index_q <= entry_i.index;
      done_q  <= entry_i.done;
      last_q  <= entry_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign coef_o      = coef_q;
  assign index_o     = index_q;
  assign done_o      = done_q;
  assign last_o      = last_q;

endmodule

// ----- src/bounded_noise_rejection_sampler.sv -----
// Channel      Direction  Payload
// s_axis       in         tdata[7:0] random_byte, tlast end_of_buffer, tuser[0] restart
// m_axis       out        tdata[18:0] coefficient, tdata[26:19] coefficient_index,
//                         tuser[0] sampling_done, tlast last_of_run
// cfg          in         cfg_we_i, cfg_idx_i register index, cfg_data_i value
//
// A byte transfer is taken every cycle while the result queue has room for two
// results; the output register delivers at most one coefficient per cycle, so a
// byte that yields two results needs two output transfers.
// A result passes through the queue and then the output register before it
// appears. Reset is asynchronous and active low and restores the register
// defaults with empty gather, count and queue. Stalls on the output side fill
// the queue and then drop s_axis_tready, with no loss of results.
module bounded_noise_rejection_sampler import bnrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] random_byte
  input  logic                s_axis_tlast,
  input  logic [0:0]          s_axis_tuser,   // [0] restart
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // [18:0] coefficient, [26:19] index, zero fill
  output logic                m_axis_tlast,
  output logic [0:0]          m_axis_tuser    // [0] sampling_done
);

  bnrs_push_t        push;
  logic              space;
  logic              q_valid;
  logic              q_pop;
  bnrs_entry_t       q_entry;
  logic [ValueW-1:0] coef;
  logic [IndexW-1:0] index;
  logic              done;

  // The front classifies each byte, tracks the gather and the produced count,
  // and writes up to two accepted candidates into the queue.
  bnrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (space),
    .in_byte_i    (s_axis_tdata),
    .in_eob_i     (s_axis_tlast),
    .in_restart_i (s_axis_tuser[0]),
    .push_o       (push)
  );

  bnrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // The back forms the signed coefficient and holds it for the output transfer.
  bnrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (q_entry),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .coef_o      (coef),
    .index_o     (index),
    .done_o      (done),
    .last_o      (m_axis_tlast)
  );

  assign s_axis_tready = space;
  assign m_axis_tdata  = {5'd0, index, coef};
  assign m_axis_tuser  = done;

endmodule
